@@ rtl/core/paes_pkg.sv @@
// Package: shared types and constants for the peer address endpoint select block.
`default_nettype none

package paes_pkg;

  // Byte positions within a descriptor
  localparam int unsigned TEXT_LEN        = 8;
  localparam int unsigned DRCT_LEN        = 4;
  localparam int unsigned DIRECT_PORT_POS = 10;
  localparam int unsigned DIRECT_TAIL_POS = 12;
  localparam int unsigned NAT_POS         = 40;
  localparam int unsigned CAND_LEN        = 6;

  // Method byte limits
  localparam logic [7:0] METHOD_MAX        = 8'd7;
  localparam logic [7:0] METHOD_TEXT_FIRST = 8'd6;

  // NAT kind range for the candidate form
  localparam logic [7:0] NAT_KIND_MIN = 8'd1;
  localparam logic [7:0] NAT_KIND_MAX = 8'd3;

  // Text-ID prefix that marks a rejected descriptor
  localparam logic [7:0] TEXT_ID_PREFIX [TEXT_LEN] = '{
    8'h73, 8'h74, 8'h65, 8'h61, 8'h6d, 8'h69, 8'h64, 8'h3a
  };

  // Direct form marker
  localparam logic [7:0] DRCT_PREFIX [DRCT_LEN] = '{8'h44, 8'h52, 8'h43, 8'h54};

  typedef enum logic [1:0] {
    VERDICT_KEPT        = 2'd0,
    VERDICT_ALTERNATE   = 2'd1,
    VERDICT_REBUILT     = 2'd2,
    VERDICT_UNAVAILABLE = 2'd3
  } verdict_e;

  typedef struct packed {
    logic [31:0] host;
    logic [15:0] port;
  } endpoint_t;

  typedef struct packed {
    logic      ok;
    endpoint_t ep;
  } ep_status_t;

  function automatic logic usable(endpoint_t ep);
    return (ep.host != '0) && (ep.port != '0);
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/paes_tracker.sv @@
// Per-descriptor validation flags and endpoint capture.
`default_nettype none

module paes_tracker import paes_pkg::*; #(
  parameter int unsigned POS_W         = 6,
  parameter int unsigned PUBLIC_OFFSET = 30
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic [7:0]       byte_i,
  input  wire logic [POS_W-1:0] pos_i,
  input  wire logic             absorb_i,
  input  wire logic             clear_i,
  output ep_status_t            status_o
);

  localparam logic [POS_W-1:0] TextEnd  = POS_W'(TEXT_LEN);
  localparam logic [POS_W-1:0] DrctEnd  = POS_W'(DRCT_LEN);
  localparam logic [POS_W-1:0] DPortPos = POS_W'(DIRECT_PORT_POS);
  localparam logic [POS_W-1:0] DTailPos = POS_W'(DIRECT_TAIL_POS);
  localparam logic [POS_W-1:0] NatPos   = POS_W'(NAT_POS);
  localparam logic [POS_W-1:0] CandEnd  = POS_W'(CAND_LEN);
  localparam logic [POS_W-1:0] PubStart = POS_W'(PUBLIC_OFFSET);
  localparam logic [POS_W-1:0] PubEnd   = POS_W'(PUBLIC_OFFSET + CAND_LEN);

  logic      text_q, text_d;
  logic      drct_q, drct_d;
  logic      dtail_q, dtail_d;
  logic      ctail_q, ctail_d;
  logic [7:0] nat_q, nat_d;
  endpoint_t dir_q, dir_d;
  endpoint_t loc_q, loc_d;
  endpoint_t pub_q, pub_d;

  logic [POS_W-1:0] pub_rel;
  assign pub_rel = pos_i - PubStart;

  always_comb begin
    text_d  = text_q;
    drct_d  = drct_q;
    dtail_d = dtail_q;
    ctail_d = ctail_q;
    nat_d   = nat_q;
    dir_d   = dir_q;
    loc_d   = loc_q;
    pub_d   = pub_q;
    if (clear_i) begin
      text_d  = 1'b1;
      drct_d  = 1'b1;
      dtail_d = 1'b1;
      ctail_d = 1'b1;
      nat_d   = '0;
      dir_d   = '0;
      loc_d   = '0;
      pub_d   = '0;
    end else if (absorb_i) begin
      if (pos_i < TextEnd && byte_i != TEXT_ID_PREFIX[pos_i[2:0]]) text_d = 1'b0;
      if (pos_i < DrctEnd && byte_i != DRCT_PREFIX[pos_i[1:0]]) drct_d = 1'b0;
      // direct host, big-endian at bytes 4..7
      if (pos_i >= DrctEnd && pos_i < TextEnd) dir_d.host[8*(2'd3 - pos_i[1:0]) +: 8] = byte_i;
      // direct port, big-endian
      if (pos_i == DPortPos) dir_d.port[15:8] = byte_i;
      if (pos_i == DPortPos + 1'b1) dir_d.port[7:0] = byte_i;
      if (pos_i >= DTailPos && byte_i != '0) dtail_d = 1'b0;
      if (pos_i == NatPos) nat_d = byte_i;
      if (pos_i > NatPos && byte_i != '0) ctail_d = 1'b0;
      // local candidate: host big-endian, port little-endian
      if (pos_i < CandEnd) begin
        if (pos_i[2]) loc_d.port[8*pos_i[0] +: 8] = byte_i;
        else loc_d.host[8*(2'd3 - pos_i[1:0]) +: 8] = byte_i;
      end
      if (pos_i >= PubStart && pos_i < PubEnd) begin
        if (pub_rel[2]) pub_d.port[8*pub_rel[0] +: 8] = byte_i;
        else pub_d.host[8*(2'd3 - pub_rel[1:0]) +: 8] = byte_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      text_q  <= 1'b1;
      drct_q  <= 1'b1;
      dtail_q <= 1'b1;
      ctail_q <= 1'b1;
      nat_q   <= '0;
      dir_q   <= '0;
      loc_q   <= '0;
      pub_q   <= '0;
    end else begin
      text_q  <= text_d;
      drct_q  <= drct_d;
      dtail_q <= dtail_d;
      ctail_q <= ctail_d;
      nat_q   <= nat_d;
      dir_q   <= dir_d;
      loc_q   <= loc_d;
      pub_q   <= pub_d;
    end
  end

  // Verdict for this descriptor, byte_i taken as the method byte
  always_comb begin
    status_o = '0;
    if (byte_i <= METHOD_MAX && !text_q) begin
      if (drct_q) begin
        status_o.ok = (byte_i == '0) && dtail_q && usable(dir_q);
        status_o.ep = dir_q;
      end else if (nat_q >= NAT_KIND_MIN && nat_q <= NAT_KIND_MAX && ctail_q) begin
        status_o.ok = usable(loc_q) || usable(pub_q);
        status_o.ep = usable(loc_q) ? loc_q : pub_q;
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/peer_address_endpoint_select.sv @@
// Top level: peer address endpoint select with byte tracking and result skid.
//
// Usage:
//   Input channel (in_valid_i / in_ready_o): one beat carries byte N of the
//   primary and of the alternate descriptor, from byte zero up to byte
//   ADDR_BYTES-1 (the method byte). Beats before the last make no result.
//   Output channel (out_valid_o / out_ready_i): one beat per descriptor pair,
//   carrying verdict, source, host and port.
//   Throughput: one input beat per cycle while in_ready_o is high.
//   The result beat is registered in the output or the skid register.
//   Verdict logic is a single combinational pass from the per-descriptor
//   flag registers plus the method byte into the output or skid register.
//   Stall: a stalled result sits in the output register; a second result can
//   park in a one-entry skid register, and in_ready_o drops only while the
//   skid is full. Non-final bytes still flow while the output waits.
//   Reset: byte position returns to zero, all flags to their start values,
//   output and skid registers empty.
//   After every method byte the trackers clear, so the next beat opens a
//   new descriptor pair.
`default_nettype none

module peer_address_endpoint_select import paes_pkg::*; #(
  parameter int unsigned ADDR_BYTES    = 42,
  parameter int unsigned PUBLIC_OFFSET = 30
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [7:0]  primary_byte_i,
  input  wire logic [7:0]  alternate_byte_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [1:0]       verdict_o,
  output logic             source_o,
  output logic [31:0]      host_ipv4_o,
  output logic [15:0]      host_port_o
);

  localparam int unsigned POS_W = $clog2(ADDR_BYTES);
  localparam logic [POS_W-1:0] LastPos = POS_W'(ADDR_BYTES - 1);

  typedef struct packed {
    verdict_e  verdict;
    logic      source;
    endpoint_t ep;
  } result_t;

  logic [POS_W-1:0] pos_q, pos_d;
  logic             in_fire, last, produce;
  ep_status_t       pri_st, alt_st;
  result_t          res;
  result_t          out_q, out_d, skid_q, skid_d;
  logic             out_valid_q, out_valid_d, skid_valid_q, skid_valid_d;

  assign in_ready_o = !skid_valid_q;
  assign in_fire    = in_valid_i && in_ready_o;
  assign last       = (pos_q == LastPos);
  assign produce    = in_fire && last;

  assign pos_d = !in_fire ? pos_q : (last ? '0 : pos_q + 1'b1);

  paes_tracker #(
    .POS_W         (POS_W),
    .PUBLIC_OFFSET (PUBLIC_OFFSET)
  ) u_pri (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .byte_i   (primary_byte_i),
    .pos_i    (pos_q),
    .absorb_i (in_fire && !last),
    .clear_i  (produce),
    .status_o (pri_st)
  );

  paes_tracker #(
    .POS_W         (POS_W),
    .PUBLIC_OFFSET (PUBLIC_OFFSET)
  ) u_alt (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .byte_i   (alternate_byte_i),
    .pos_i    (pos_q),
    .absorb_i (in_fire && !last),
    .clear_i  (produce),
    .status_o (alt_st)
  );

  // Selection order: a descriptor with a non-text method wins first
  always_comb begin
    priority if (pri_st.ok && primary_byte_i < METHOD_TEXT_FIRST) begin
      res = '{verdict: VERDICT_KEPT, source: 1'b0, ep: pri_st.ep};
    end else if (alt_st.ok && alternate_byte_i < METHOD_TEXT_FIRST) begin
      res = '{verdict: VERDICT_ALTERNATE, source: 1'b1, ep: alt_st.ep};
    end else if (pri_st.ok) begin
      res = '{verdict: VERDICT_REBUILT, source: 1'b0, ep: pri_st.ep};
    end else if (alt_st.ok) begin
      res = '{verdict: VERDICT_REBUILT, source: 1'b1, ep: alt_st.ep};
    end else begin
      res = '{verdict: VERDICT_UNAVAILABLE, source: 1'b0, ep: '0};
    end
  end

  // Output register plus one-entry skid
  always_comb begin
    out_d        = out_q;
    out_valid_d  = out_valid_q;
    skid_d       = skid_q;
    skid_valid_d = skid_valid_q;
    if (!out_valid_q) begin
      out_valid_d = produce;
      out_d       = res;
    end else if (out_ready_i) begin
      if (skid_valid_q) begin
        out_d        = skid_q;
        skid_valid_d = 1'b0;
      end else begin
        out_valid_d = produce;
        out_d       = res;
      end
    end else if (produce) begin
      skid_d       = res;
      skid_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q        <= '0;
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      pos_q        <= pos_d;
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign out_valid_o = out_valid_q;
  assign verdict_o   = out_q.verdict;
  assign source_o    = out_q.source;
  assign host_ipv4_o = out_q.ep.host;
  assign host_port_o = out_q.ep.port;

endmodule

`default_nettype wire

@@ rtl/core/paes_checker.sv @@
// Port-level checker for the peer address endpoint select block, with bind.
`default_nettype none

module paes_checker import paes_pkg::*; (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_ready_o,
  input wire logic [7:0]  primary_byte_i,
  input wire logic [7:0]  alternate_byte_i,
  input wire logic        out_valid_o,
  input wire logic        out_ready_i,
  input wire logic [1:0]  verdict_o,
  input wire logic        source_o,
  input wire logic [31:0] host_ipv4_o,
  input wire logic [15:0] host_port_o
);

  // Input beat waiting for ready holds
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |=> in_valid_i && $stable(primary_byte_i) &&
    $stable(alternate_byte_i))
    else $error("input beat changed while waiting");

  // Stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(verdict_o) &&
    $stable(source_o) && $stable(host_ipv4_o) && $stable(host_port_o))
    else $error("result beat changed while stalled");

  a_unavail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && verdict_o == VERDICT_UNAVAILABLE |->
    source_o == 1'b0 && host_ipv4_o == '0 && host_port_o == '0)
    else $error("unavailable verdict with nonzero endpoint");

  a_source_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (verdict_o == VERDICT_KEPT || verdict_o == VERDICT_ALTERNATE) |->
    source_o == (verdict_o == VERDICT_ALTERNATE))
    else $error("source disagrees with verdict");

  a_endpoint_usable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && verdict_o != VERDICT_UNAVAILABLE |->
    host_ipv4_o != '0 && host_port_o != '0)
    else $error("selected endpoint not dialable");

endmodule

bind peer_address_endpoint_select paes_checker u_paes_checker (.*);

`default_nettype wire
